// ----- rtl/madt_pkg.sv -----
// types and constants shared by the madt local apic parser
package madt_pkg;

  localparam logic [31:0] SIG_APIC            = 32'h4349_5041;
  localparam logic [31:0] HEADER_LEN          = 32'd44;
  localparam logic [7:0]  TYPE_LOCAL_APIC     = 8'd0;
  localparam logic [7:0]  MIN_ENTRY_LEN       = 8'd2;
  localparam logic [7:0]  MIN_LAPIC_ENTRY_LEN = 8'd8;
  localparam logic [1:0]  FLAG_ENABLED        = 2'b01;
  localparam logic [1:0]  FLAG_ONLINE_CAPABLE = 2'b10;
  localparam logic [31:0] SIG_END_POS         = 32'd4;
  localparam logic [31:0] LEN_END_POS         = 32'd8;
  localparam logic [31:0] LEN_LAST_POS        = 32'd7;
  localparam logic [31:0] BASE_FIRST_POS      = 32'd36;
  localparam logic [31:0] BASE_END_POS        = 32'd40;

  // register word index on the apb port
  localparam logic REG_BOOTSTRAP_APIC_ID = 1'b0;

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef enum logic {
    KIND_CPU     = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        last_of_run;
    logic [5:0]  cpu_index;
    logic [7:0]  processor_uid;
    logic [7:0]  apic_id;
    logic        cpu_enabled;
    logic        is_bootstrap;
    logic        checksum_ok;
    logic        header_ok;
    logic [31:0] lapic_address;
    logic [6:0]  entries_recorded;
    logic [6:0]  enabled_total;
  } result_t;

  function automatic logic [7:0] sig_byte(input logic [1:0] idx);
    logic [31:0] shifted;
    shifted  = SIG_APIC >> {idx, 3'b000};
    sig_byte = shifted[7:0];
  endfunction

endpackage

// ----- rtl/madt_local_apic_parser.sv -----
// madt local apic parser top level: byte parse, cpu records and result queue
// Takes one MADT table byte per cycle, sustained, while table_ready is high, and reports every
// recorded local APIC entry on the entry's last byte and a summary on the table's last byte
// (or at byte 7 when the length field is below 44). A byte goes straight from the input port
// through the parse logic into a four-entry result queue, so the first result is visible in
// the cycle after its byte is taken. A byte that ends both a CPU entry and the table writes
// two results, and since the queue has a single read port those two leave one after the
// other. table_ready is high while the queue has room for two results. bootstrap_apic_id is
// written through the APB port at byte address 0 and should only change between tables.
module madt_local_apic_parser
  import madt_pkg::*;
#(
  parameter int MAX_CPUS = 64
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  input  logic        table_valid,
  output logic        table_ready,
  input  logic [7:0]  table_byte,
  input  logic        table_start,

  output logic        result_valid,
  input  logic        result_ready,
  output logic        result_kind,
  output logic        last_of_run,
  output logic [5:0]  cpu_index,
  output logic [7:0]  processor_uid,
  output logic [7:0]  apic_id,
  output logic        cpu_enabled,
  output logic        is_bootstrap,
  output logic        checksum_ok,
  output logic        header_ok,
  output logic [31:0] lapic_address,
  output logic [6:0]  entries_recorded,
  output logic [6:0]  enabled_total
);

  localparam int CW = $clog2(MAX_CPUS + 1);

  // configuration
  logic [7:0] bootstrap_apic_id;

  // parse state
  logic [31:0]   byte_position,   byte_position_next;
  logic [31:0]   table_length,    table_length_next;
  logic [7:0]    running_sum,     running_sum_next;
  logic          signature_match, signature_match_next;
  logic [31:0]   apic_base,       apic_base_next;
  logic [7:0]    entry_offset,    entry_offset_next;
  logic [7:0]    entry_type,      entry_type_next;
  logic [7:0]    entry_length,    entry_length_next;
  logic [7:0]    entry_uid,       entry_uid_next;
  logic [7:0]    entry_apic,      entry_apic_next;
  logic [1:0]    entry_flag_bits, entry_flag_bits_next;
  logic          walk_stopped,    walk_stopped_next;
  logic [CW-1:0] entry_count,     entry_count_next;
  logic [CW-1:0] enabled_count,   enabled_count_next;
  logic [5:0]    bootstrap_slot,  bootstrap_slot_next;
  logic          bootstrap_seen,  bootstrap_seen_next;

  // state after an optional table start
  logic [31:0]   cur_position;
  logic [31:0]   cur_length;
  logic [7:0]    cur_sum;
  logic          cur_sig;
  logic [31:0]   cur_base;
  logic [7:0]    cur_offset;
  logic [7:0]    cur_type;
  logic [7:0]    cur_len;
  logic [7:0]    cur_uid;
  logic [7:0]    cur_apic;
  logic [1:0]    cur_flags;
  logic          cur_stopped;
  logic [CW-1:0] cur_count;
  logic [CW-1:0] cur_enabled;
  logic [5:0]    cur_bslot;
  logic          cur_bseen;

  logic          accept;
  logic          in_table;
  logic          hdr_full;
  logic          active;
  logic          walk;
  logic [7:0]    len_eff;
  logic [7:0]    offset_inc;
  logic          overrun;
  logic          record_try;
  logic          do_record;
  logic          cpu_en;
  logic          cpu_bsp;
  logic          sum_short;
  logic          sum_long;
  logic          do_summary;
  result_t       cpu_res;
  result_t       sum_res;
  result_t       push_data0;
  result_t       push_data1;
  logic          push0;
  logic          push1;

  // result queue
  result_t              fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr, wr_ptr_next;
  logic [FIFO_AW-1:0]   rd_ptr, rd_ptr_next;
  logic [FIFO_AW:0]     count,  count_next;
  logic                 pop;
  result_t              head;

  assign accept      = table_valid && table_ready;
  assign table_ready = count <= (FIFO_AW + 1)'(FIFO_DEPTH - 2);
  assign pop         = result_valid && result_ready;

  // apb port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BOOTSTRAP_APIC_ID) ? {24'd0, bootstrap_apic_id} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bootstrap_apic_id <= 8'd0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_BOOTSTRAP_APIC_ID) begin
      bootstrap_apic_id <= pwdata[7:0];
    end
  end

  always_comb begin
    if (table_start) begin
      cur_position = 32'd0;
      cur_length   = 32'd0;
      cur_sum      = 8'd0;
      cur_sig      = 1'b1;
      cur_base     = 32'd0;
      cur_offset   = 8'd0;
      cur_type     = 8'd0;
      cur_len      = 8'd0;
      cur_uid      = 8'd0;
      cur_apic     = 8'd0;
      cur_flags    = 2'd0;
      cur_stopped  = 1'b0;
      cur_count    = '0;
      cur_enabled  = '0;
      cur_bslot    = 6'd0;
      cur_bseen    = 1'b0;
    end else begin
      cur_position = byte_position;
      cur_length   = table_length;
      cur_sum      = running_sum;
      cur_sig      = signature_match;
      cur_base     = apic_base;
      cur_offset   = entry_offset;
      cur_type     = entry_type;
      cur_len      = entry_length;
      cur_uid      = entry_uid;
      cur_apic     = entry_apic;
      cur_flags    = entry_flag_bits;
      cur_stopped  = walk_stopped;
      cur_count    = entry_count;
      cur_enabled  = enabled_count;
      cur_bslot    = bootstrap_slot;
      cur_bseen    = bootstrap_seen;
    end

    // header bytes
    signature_match_next = cur_sig;
    table_length_next    = cur_length;
    if (cur_position < SIG_END_POS) begin
      if (table_byte != sig_byte(cur_position[1:0])) begin
        signature_match_next = 1'b0;
      end
    end else if (cur_position < LEN_END_POS) begin
      table_length_next = cur_length | ({24'd0, table_byte} << {cur_position[1:0], 3'b000});
    end

    in_table = cur_position < table_length_next;
    running_sum_next = (cur_position < LEN_END_POS || in_table) ? cur_sum + table_byte : cur_sum;

    hdr_full  = table_length_next >= HEADER_LEN;
    sum_short = (cur_position == LEN_LAST_POS) && !hdr_full;
    active    = hdr_full && in_table;

    apic_base_next = cur_base;
    if (active && cur_position >= BASE_FIRST_POS && cur_position < BASE_END_POS) begin
      apic_base_next = cur_base | ({24'd0, table_byte} << {cur_position[1:0], 3'b000});
    end

    // entry walk
    walk       = active && cur_position >= HEADER_LEN && !cur_stopped;
    len_eff    = (cur_offset == 8'd1) ? table_byte : cur_len;
    offset_inc = cur_offset + 8'd1;
    overrun    = ({1'b0, cur_position} - 33'd1 + {25'd0, table_byte}) > {1'b0, table_length_next};

    entry_offset_next    = cur_offset;
    entry_type_next      = cur_type;
    entry_length_next    = cur_len;
    entry_uid_next       = cur_uid;
    entry_apic_next      = cur_apic;
    entry_flag_bits_next = cur_flags;
    walk_stopped_next    = cur_stopped;
    record_try           = 1'b0;

    if (walk) begin
      case (cur_offset)
        8'd0:    entry_type_next      = table_byte;
        8'd1:    entry_length_next    = table_byte;
        8'd2:    entry_uid_next       = table_byte;
        8'd3:    entry_apic_next      = table_byte;
        8'd4:    entry_flag_bits_next = table_byte[1:0];
        default: ;
      endcase
      if (cur_offset == 8'd1 && (table_byte < MIN_ENTRY_LEN || overrun)) begin
        walk_stopped_next = 1'b1;
        entry_offset_next = 8'd0;
      end else if (cur_offset != 8'd0 && offset_inc == len_eff) begin
        record_try        = (cur_type == TYPE_LOCAL_APIC) && (len_eff >= MIN_LAPIC_ENTRY_LEN);
        entry_offset_next = 8'd0;
      end else begin
        entry_offset_next = offset_inc;
      end
    end

    // cpu record
    do_record = record_try && (cur_count < CW'(MAX_CPUS));
    cpu_en    = |(cur_flags & (FLAG_ENABLED | FLAG_ONLINE_CAPABLE));
    cpu_bsp   = cur_apic == bootstrap_apic_id;

    entry_count_next    = cur_count;
    enabled_count_next  = cur_enabled;
    bootstrap_slot_next = cur_bslot;
    bootstrap_seen_next = cur_bseen;
    if (do_record) begin
      entry_count_next = cur_count + CW'(1);
      if (cpu_en) begin
        enabled_count_next = cur_enabled + CW'(1);
      end
      if (cpu_bsp) begin
        bootstrap_slot_next = 6'(cur_count);
        bootstrap_seen_next = 1'b1;
      end
    end

    sum_long   = active && (cur_position == table_length_next - 32'd1);
    do_summary = sum_short || sum_long;

    byte_position_next = (cur_position == 32'hFFFF_FFFF) ? cur_position : cur_position + 32'd1;

    cpu_res                  = '0;
    cpu_res.kind             = KIND_CPU;
    cpu_res.last_of_run      = !do_summary;
    cpu_res.cpu_index        = 6'(cur_count);
    cpu_res.processor_uid    = cur_uid;
    cpu_res.apic_id          = cur_apic;
    cpu_res.cpu_enabled      = cpu_en;
    cpu_res.is_bootstrap     = cpu_bsp;

    sum_res                  = '0;
    sum_res.kind             = KIND_SUMMARY;
    sum_res.last_of_run      = 1'b1;
    sum_res.cpu_index        = bootstrap_slot_next;
    sum_res.is_bootstrap     = bootstrap_seen_next;
    sum_res.checksum_ok      = sum_long && (running_sum_next == 8'd0);
    sum_res.header_ok        = sum_long && signature_match_next;
    sum_res.lapic_address    = apic_base_next;
    sum_res.entries_recorded = 7'(entry_count_next);
    sum_res.enabled_total    = 7'(enabled_count_next);

    push0      = accept && (do_record || do_summary);
    push1      = accept && do_record && do_summary;
    push_data0 = do_record ? cpu_res : sum_res;
    push_data1 = sum_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= 32'd0;
      table_length    <= 32'd0;
      running_sum     <= 8'd0;
      signature_match <= 1'b1;
      apic_base       <= 32'd0;
      entry_offset    <= 8'd0;
      entry_type      <= 8'd0;
      entry_length    <= 8'd0;
      entry_uid       <= 8'd0;
      entry_apic      <= 8'd0;
      entry_flag_bits <= 2'd0;
      walk_stopped    <= 1'b0;
      entry_count     <= '0;
      enabled_count   <= '0;
      bootstrap_slot  <= 6'd0;
      bootstrap_seen  <= 1'b0;
    end else if (accept) begin
      byte_position   <= byte_position_next;
      table_length    <= table_length_next;
      running_sum     <= running_sum_next;
      signature_match <= signature_match_next;
      apic_base       <= apic_base_next;
      entry_offset    <= entry_offset_next;
      entry_type      <= entry_type_next;
      entry_length    <= entry_length_next;
      entry_uid       <= entry_uid_next;
      entry_apic      <= entry_apic_next;
      entry_flag_bits <= entry_flag_bits_next;
      walk_stopped    <= walk_stopped_next;
      entry_count     <= entry_count_next;
      enabled_count   <= enabled_count_next;
      bootstrap_slot  <= bootstrap_slot_next;
      bootstrap_seen  <= bootstrap_seen_next;
    end
  end

  // result queue control
  always_comb begin
    wr_ptr_next = wr_ptr;
    if (push1) begin
      wr_ptr_next = wr_ptr + FIFO_AW'(2);
    end else if (push0) begin
      wr_ptr_next = wr_ptr + FIFO_AW'(1);
    end
    rd_ptr_next = pop ? rd_ptr + FIFO_AW'(1) : rd_ptr;
    count_next  = count + (FIFO_AW + 1)'(push0) + (FIFO_AW + 1)'(push1)
                  - (FIFO_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      fifo_mem[wr_ptr] <= push_data0;
    end
    if (push1) begin
      fifo_mem[wr_ptr + FIFO_AW'(1)] <= push_data1;
    end
  end

  assign head             = fifo_mem[rd_ptr];
  assign result_valid     = count != '0;
  assign result_kind      = head.kind;
  assign last_of_run      = head.last_of_run;
  assign cpu_index        = head.cpu_index;
  assign processor_uid    = head.processor_uid;
  assign apic_id          = head.apic_id;
  assign cpu_enabled      = head.cpu_enabled;
  assign is_bootstrap     = head.is_bootstrap;
  assign checksum_ok      = head.checksum_ok;
  assign header_ok        = head.header_ok;
  assign lapic_address    = head.lapic_address;
  assign entries_recorded = head.entries_recorded;
  assign enabled_total    = head.enabled_total;

  // checks
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (FIFO_AW + 1)'(FIFO_DEPTH))
    else $error("result queue overfilled");

  a_cpu_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(MAX_CPUS))
    else $error("recorded more cpus than capacity");

  a_enabled_bound: assert property (@(posedge clk) disable iff (rst)
    enabled_count <= entry_count)
    else $error("enabled count above recorded count");

  a_stop_needs_header: assert property (@(posedge clk) disable iff (rst)
    walk_stopped |-> table_length >= HEADER_LEN)
    else $error("entry walk stopped without a full header");

  a_bslot_clean: assert property (@(posedge clk) disable iff (rst)
    !bootstrap_seen |-> bootstrap_slot == 6'd0)
    else $error("bootstrap slot set without a bootstrap match");

endmodule

// ----- tb/sv/tb_top.sv -----
// testbench for madt_local_apic_parser: table byte stream, cpu reports and summaries checked
`timescale 1ns / 100ps

module tb_top
  import madt_pkg::*;
;

  localparam int CPU_SLOTS   = 64;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0] b;
    logic       first;
  } feed_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        table_valid = 1'b0;
  logic        table_ready;
  logic [7:0]  table_byte = '0;
  logic        table_start = 1'b0;

  logic        result_valid;
  logic        result_ready = 1'b0;
  logic        result_kind;
  logic        last_of_run;
  logic [5:0]  cpu_index;
  logic [7:0]  processor_uid;
  logic [7:0]  apic_id;
  logic        cpu_enabled;
  logic        is_bootstrap;
  logic        checksum_ok;
  logic        header_ok;
  logic [31:0] lapic_address;
  logic [6:0]  entries_recorded;
  logic [6:0]  enabled_total;

  // parser copy
  logic [31:0] p_pos;
  logic [31:0] p_len;
  logic [7:0]  p_sum;
  logic        p_sig;
  logic [31:0] p_base;
  logic [7:0]  p_off;
  logic [7:0]  p_type;
  logic [7:0]  p_elen;
  logic [7:0]  p_uid;
  logic [7:0]  p_apic;
  logic [1:0]  p_flags;
  logic        p_halt;
  logic [6:0]  p_cnt;
  logic [6:0]  p_encnt;
  logic [5:0]  p_bslot;
  logic        p_bseen;
  logic [7:0]  p_bsp_id;

  feed_t       byte_feed[$];
  result_t     pending_reports[$];
  logic [7:0]  tbl[$];

  int gap_pct = 11;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int cpus_checked = 0;
  int summaries_checked = 0;
  int bytes_taken = 0;
  int table_bytes = 0;
  int est_reports = 0;
  int tables_sent = 0;
  int cfg_writes = 0;

  madt_local_apic_parser #(
    .MAX_CPUS(CPU_SLOTS)
  ) i_dut (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .table_valid      (table_valid),
    .table_ready      (table_ready),
    .table_byte       (table_byte),
    .table_start      (table_start),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .result_kind      (result_kind),
    .last_of_run      (last_of_run),
    .cpu_index        (cpu_index),
    .processor_uid    (processor_uid),
    .apic_id          (apic_id),
    .cpu_enabled      (cpu_enabled),
    .is_bootstrap     (is_bootstrap),
    .checksum_ok      (checksum_ok),
    .header_ok        (header_ok),
    .lapic_address    (lapic_address),
    .entries_recorded (entries_recorded),
    .enabled_total    (enabled_total)
  );

  initial forever #2 clk = ~clk;

  function automatic void clear_parse();
    p_pos   = '0;
    p_len   = '0;
    p_sum   = '0;
    p_sig   = 1'b1;
    p_base  = '0;
    p_off   = '0;
    p_type  = '0;
    p_elen  = '0;
    p_uid   = '0;
    p_apic  = '0;
    p_flags = '0;
    p_halt  = 1'b0;
    p_cnt   = '0;
    p_encnt = '0;
    p_bslot = '0;
    p_bseen = 1'b0;
  endfunction

  function automatic result_t summary_of(input logic whole);
    result_t s;
    s = '0;
    s.kind             = KIND_SUMMARY;
    s.cpu_index        = p_bslot;
    s.is_bootstrap     = p_bseen;
    s.checksum_ok      = whole && (p_sum == 8'h00);
    s.header_ok        = whole && p_sig;
    s.lapic_address    = p_base;
    s.entries_recorded = p_cnt;
    s.enabled_total    = p_encnt;
    return s;
  endfunction

  // works out the reports caused by one table byte
  task automatic parse_table_byte(input logic [7:0] b, input logic first);
    result_t     made[2];
    int          n;
    int          off;
    logic [31:0] pos;
    logic [31:0] sig_word;
    logic        en;
    logic        bsp;
    logic        cut;
    n = 0;
    cut = 1'b0;
    if (first) clear_parse();
    pos = p_pos;
    if (pos < SIG_END_POS) begin
      sig_word = SIG_APIC >> (8 * pos[1:0]);
      if (b != sig_word[7:0]) p_sig = 1'b0;
    end else if (pos < LEN_END_POS) begin
      p_len[8*pos[1:0] +: 8] = b;
    end
    if (pos < LEN_END_POS || pos < p_len) p_sum = p_sum + b;
    if (pos == LEN_LAST_POS && p_len < HEADER_LEN) begin
      made[n] = summary_of(1'b0);
      n++;
    end
    if (p_len >= HEADER_LEN && pos < p_len) begin
      if (pos >= BASE_FIRST_POS && pos < BASE_END_POS) p_base[8*pos[1:0] +: 8] = b;
      if (pos >= HEADER_LEN && !p_halt) begin
        off = int'(p_off);
        case (off)
          0: p_type = b;
          1: begin
            p_elen = b;
            if (b < MIN_ENTRY_LEN || longint'(pos) - 1 + longint'(b) > longint'(p_len)) begin
              p_halt = 1'b1;
              p_off = '0;
              cut = 1'b1;
            end
          end
          2: p_uid = b;
          3: p_apic = b;
          4: p_flags = b[1:0];
          default: ;
        endcase
        if (!cut) begin
          if (off >= 1 && off + 1 == int'(p_elen)) begin
            if (p_type == TYPE_LOCAL_APIC && p_elen >= MIN_LAPIC_ENTRY_LEN &&
                p_cnt < CPU_SLOTS) begin
              en  = (p_flags & (FLAG_ENABLED | FLAG_ONLINE_CAPABLE)) != 2'b00;
              bsp = (p_apic == p_bsp_id);
              made[n] = '0;
              made[n].kind          = KIND_CPU;
              made[n].cpu_index     = p_cnt[5:0];
              made[n].processor_uid = p_uid;
              made[n].apic_id       = p_apic;
              made[n].cpu_enabled   = en;
              made[n].is_bootstrap  = bsp;
              if (bsp) begin
                p_bslot = p_cnt[5:0];
                p_bseen = 1'b1;
              end
              p_cnt++;
              if (en) p_encnt++;
              n++;
            end
            p_off = '0;
          end else begin
            p_off = 8'(off + 1);
          end
        end
      end
      if (pos == p_len - 1) begin
        made[n] = summary_of(1'b1);
        n++;
      end
    end
    if (p_pos != '1) p_pos++;
    if (n > 0) made[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) pending_reports.push_back(made[i]);
  endtask

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // request driver
  always @(posedge clk) begin : drive
    feed_t nxt;
    if (rst) begin
      table_valid <= 1'b0;
      clear_parse();
      p_bsp_id = '0;
    end else begin
      if (table_valid && table_ready) begin
        parse_table_byte(table_byte, table_start);
        bytes_taken++;
      end
      if (!table_valid || table_ready) begin
        if (byte_feed.size() != 0 && $urandom_range(99) >= gap_pct) begin
          nxt = byte_feed.pop_front();
          table_valid <= 1'b1;
          table_byte  <= nxt.b;
          table_start <= nxt.first;
        end else begin
          table_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= gap_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin : observe
    result_t w;
    if (!rst && result_valid && result_ready) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result, kind %0d", result_kind);
        mismatches++;
      end else begin
        w = pending_reports.pop_front();
        check_field("result_kind", w.kind, result_kind);
        check_field("last_of_run", w.last_of_run, last_of_run);
        check_field("cpu_index", w.cpu_index, cpu_index);
        check_field("processor_uid", w.processor_uid, processor_uid);
        check_field("apic_id", w.apic_id, apic_id);
        check_field("cpu_enabled", w.cpu_enabled, cpu_enabled);
        check_field("is_bootstrap", w.is_bootstrap, is_bootstrap);
        check_field("checksum_ok", w.checksum_ok, checksum_ok);
        check_field("header_ok", w.header_ok, header_ok);
        check_field("lapic_address", w.lapic_address, lapic_address);
        check_field("entries_recorded", w.entries_recorded, entries_recorded);
        check_field("enabled_total", w.enabled_total, enabled_total);
        if (w.kind == KIND_SUMMARY) summaries_checked++;
        else cpus_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (table_valid && table_ready) || (result_valid && result_ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("madt_local_apic_parser: mismatch");
        $finish;
      end
    end
  end

  task automatic cfg_write(input logic [7:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_BOOTSTRAP_APIC_ID, 2'b00};
    pwdata  <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    p_bsp_id = value;
    cfg_writes++;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (byte_feed.size() != 0 || table_valid || pending_reports.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic begin_table(input logic [31:0] base);
    logic [31:0] sig_word;
    tbl.delete();
    for (int i = 0; i < int'(HEADER_LEN); i++) begin
      if (i < 4) begin
        sig_word = SIG_APIC >> (8 * i);
        tbl.push_back(sig_word[7:0]);
      end else if (i < 10) begin
        tbl.push_back(8'h00);
      end else if (i >= 36 && i < 40) begin
        tbl.push_back(base[8*(i-36) +: 8]);
      end else begin
        tbl.push_back(8'($urandom));
      end
    end
  endtask

  task automatic add_entry(input logic [7:0] etype, input logic [7:0] elen,
                           input logic [7:0] uid, input logic [7:0] apic,
                           input logic [7:0] flags);
    tbl.push_back(etype);
    tbl.push_back(elen);
    for (int i = 2; i < elen; i++)
      tbl.push_back(i == 2 ? uid : i == 3 ? apic : i == 4 ? flags : 8'($urandom));
    if (etype == TYPE_LOCAL_APIC && elen >= MIN_LAPIC_ENTRY_LEN) est_reports++;
  endtask

  // len_field below zero means the real size
  task automatic ship_table(input longint len_field, input bit bad_sum, input bit with_start);
    logic [31:0] l;
    logic [7:0]  s;
    l = (len_field < 0) ? 32'(tbl.size()) : 32'(len_field);
    for (int i = 0; i < 4; i++) tbl[4+i] = l[8*i +: 8];
    tbl[9] = 8'h00;
    s = 8'h00;
    foreach (tbl[i]) if (i < 8 || i < l) s = s + tbl[i];
    tbl[9] = 8'h00 - s + {7'b0, bad_sum};
    est_reports++;
    table_bytes += tbl.size();
    tables_sent++;
    @(negedge clk);
    foreach (tbl[i]) byte_feed.push_back('{tbl[i], with_start && (i == 0)});
  endtask

  task automatic push_noise(input int n, input bit may_start);
    @(negedge clk);
    repeat (n) byte_feed.push_back('{8'($urandom), may_start && ($urandom_range(4) == 0)});
  endtask

  task automatic add_random_entry();
    int r;
    r = $urandom_range(99);
    if (r < 65)
      add_entry(TYPE_LOCAL_APIC,
                ($urandom_range(4) == 0) ? 8'($urandom_range(8, 16)) : MIN_LAPIC_ENTRY_LEN,
                8'($urandom), ($urandom_range(3) == 0) ? p_bsp_id : 8'($urandom),
                8'($urandom));
    else if (r < 80)
      add_entry(TYPE_LOCAL_APIC, 8'($urandom_range(2, 7)), 8'($urandom), 8'($urandom),
                8'($urandom));
    else
      add_entry(8'($urandom_range(1, 255)), 8'($urandom_range(2, 16)), 8'($urandom),
                8'($urandom), 8'($urandom));
  endtask

  task automatic random_table();
    int n;
    int f;
    int k;
    begin_table($urandom);
    n = $urandom_range(6);
    repeat (n) add_random_entry();
    f = $urandom_range(99);
    if (f < 8) begin
      tbl.push_back(8'($urandom));
    end else if (f < 14) begin
      add_entry(8'($urandom), 8'($urandom_range(1)), 8'h00, 8'h00, 8'h00);
      add_random_entry();
    end else if (f < 20) begin
      add_entry(TYPE_LOCAL_APIC, MIN_LAPIC_ENTRY_LEN, 8'($urandom), 8'($urandom),
                8'($urandom));
      tbl[tbl.size() - 7] = 8'($urandom_range(9, 255));
    end
    if ($urandom_range(19) == 0) begin
      k = $urandom_range(3);
      tbl[k] = tbl[k] ^ 8'(1 << $urandom_range(7));
    end
    ship_table(-1, $urandom_range(9) == 0, $urandom_range(19) != 0);
  endtask

  task automatic run_random(input int bytes_goal, input int reports_goal);
    int b0;
    int e0;
    int pick;
    b0 = table_bytes;
    e0 = est_reports;
    while (table_bytes - b0 < bytes_goal || est_reports - e0 < reports_goal) begin
      pick = $urandom_range(99);
      if (pick < 78) begin
        random_table();
      end else if (pick < 86) begin
        begin_table($urandom);
        tbl = tbl[0:$urandom_range(9, 29)];
        ship_table($urandom_range(43), 1'b0, 1'b1);
      end else if (pick < 93) begin
        push_noise($urandom_range(1, 6), 1'b1);
      end else begin
        // table cut short by the next start
        begin_table($urandom);
        repeat ($urandom_range(1, 3)) add_random_entry();
        ship_table(longint'(tbl.size()) + $urandom_range(1, 60), 1'b0, 1'b1);
      end
      if ($urandom_range(9) == 0) push_noise($urandom_range(1, 4), 1'b0);
    end
    wait_idle();
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // first table without a start mark, bootstrap id at reset value
    begin_table(32'hFEE0_0000);
    add_entry(TYPE_LOCAL_APIC, MIN_LAPIC_ENTRY_LEN, 8'h00, 8'h00, 8'h01);
    add_entry(TYPE_LOCAL_APIC, MIN_LAPIC_ENTRY_LEN, 8'hFF, 8'hFF, 8'h02);
    add_entry(8'd1, 8'd12, 8'h01, 8'h00, 8'h00);
    add_entry(TYPE_LOCAL_APIC, 8'd6, 8'h04, 8'h00, 8'h01);
    add_entry(TYPE_LOCAL_APIC, 8'd10, 8'h05, 8'h00, 8'hFC);
    add_entry(8'hFF, MIN_ENTRY_LEN, 8'h00, 8'h00, 8'h00);
    add_entry(TYPE_LOCAL_APIC, MIN_LAPIC_ENTRY_LEN, 8'h06, 8'h07, 8'h03);
    ship_table(-1, 1'b0, 1'b0);
    wait_idle();

    cfg_write(8'hFF);
    // bad signature and checksum, zero length entry halts the walk
    begin_table(32'h0000_0000);
    tbl[0] = 8'h00;
    add_entry(TYPE_LOCAL_APIC, MIN_LAPIC_ENTRY_LEN, 8'h10, 8'hFF, 8'h01);
    add_entry(TYPE_LOCAL_APIC, 8'd0, 8'h00, 8'h00, 8'h00);
    add_entry(TYPE_LOCAL_APIC, MIN_LAPIC_ENTRY_LEN, 8'h11, 8'hFF, 8'h01);
    ship_table(-1, 1'b1, 1'b1);
    // entry running past the table end
    begin_table(32'hFFFF_FFFF);
    add_entry(TYPE_LOCAL_APIC, MIN_LAPIC_ENTRY_LEN, 8'h20, 8'h01, 8'h80);
    add_entry(TYPE_LOCAL_APIC, MIN_LAPIC_ENTRY_LEN, 8'h21, 8'hFF, 8'h01);
    tbl[tbl.size() - 7] = 8'd9;
    ship_table(-1, 1'b0, 1'b1);
    // one byte entry halts the walk
    begin_table(32'h1234_5678);
    add_entry(TYPE_LOCAL_APIC, MIN_LAPIC_ENTRY_LEN, 8'h30, 8'hFF, 8'h02);
    add_entry(TYPE_LOCAL_APIC, 8'd1, 8'h00, 8'h00, 8'h00);
    add_entry(TYPE_LOCAL_APIC, MIN_LAPIC_ENTRY_LEN, 8'h31, 8'h02, 8'h01);
    ship_table(-1, 1'b0, 1'b1);
    // trailing fragment of an entry header
    begin_table(32'hFEC0_0000);
    add_entry(TYPE_LOCAL_APIC, MIN_LAPIC_ENTRY_LEN, 8'h40, 8'h03, 8'h00);
    tbl.push_back(TYPE_LOCAL_APIC);
    ship_table(-1, 1'b0, 1'b1);
    // short lengths, bytes past the end
    begin_table(32'h0);
    tbl = tbl[0:9];
    ship_table(0, 1'b0, 1'b1);
    push_noise(3, 1'b0);
    begin_table(32'hA5A5_5A5A);
    ship_table(43, 1'b0, 1'b1);
    // header only
    begin_table(32'h8000_0001);
    ship_table(-1, 1'b0, 1'b1);
    push_noise(4, 1'b0);
    wait_idle();

    cfg_write(8'($urandom_range(1, 254)));
    run_random(60, 2);

    // no idling on either side
    gap_pct = 0;
    cfg_write(8'h00);
    run_random(40, 1);
    gap_pct = 11;

    // long result stall on a table of back to back cpu entries
    cfg_write(8'($urandom_range(255)));
    @(negedge clk);
    hold_requests++;
    begin_table($urandom);
    repeat (6)
      add_entry(TYPE_LOCAL_APIC, MIN_LAPIC_ENTRY_LEN, 8'($urandom),
                ($urandom_range(7) == 0) ? p_bsp_id : 8'($urandom), 8'($urandom));
    ship_table(-1, 1'b0, 1'b1);
    wait_idle();

    $display("%0d table bytes in %0d tables, %0d bootstrap id writes, one long result stall",
             bytes_taken, tables_sent, cfg_writes);
    $display("%0d cpu reports and %0d summaries checked", cpus_checked, summaries_checked);
    if (mismatches == 0) begin
      $display("madt_local_apic_parser: match");
    end else begin
      $display("madt_local_apic_parser: mismatch");
    end
    $finish;
  end

endmodule
